[hw/rtl/escaped_terminator_detector_core_macros.svh]
// Assertion macros for the escaped terminator detector.
// Used by etd_step for its concurrent checks; needs clock and reset in scope.
`ifndef ESCAPED_TERMINATOR_DETECTOR_CORE_MACROS_SVH
`define ESCAPED_TERMINATOR_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ETD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define ETD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/etd_pkg.sv]
// Shared types and constants for the escaped terminator detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package etd_pkg;

   localparam int MAX_TERM_BYTES_DEF = 8;
   localparam int COUNT_BITS_DEF     = 16;

   localparam int TERM_BITS   = 64;
   localparam int TLEN_BITS   = 4;
   localparam int LEN_BITS    = 17;
   localparam int MAXLEN_BITS = 16;

   // source event codes
   localparam logic [1:0] EV_BYTE    = 2'd0;
   localparam logic [1:0] EV_EOD     = 2'd1;
   localparam logic [1:0] EV_ERROR   = 2'd2;
   localparam logic [1:0] EV_TIMEOUT = 2'd3;

   // end status codes
   localparam logic [2:0] ST_RUNNING  = 3'd0;
   localparam logic [2:0] ST_TERM     = 3'd1;
   localparam logic [2:0] ST_TOO_LONG = 3'd2;
   localparam logic [2:0] ST_EOD      = 3'd3;
   localparam logic [2:0] ST_ERROR    = 3'd4;
   localparam logic [2:0] ST_TIMEOUT  = 3'd5;

   // register indexes
   localparam logic [1:0] CSR_TERM_BYTES  = 2'd0;
   localparam logic [1:0] CSR_TERM_LENGTH = 2'd1;
   localparam logic [1:0] CSR_ESCAPE_BYTE = 2'd2;
   localparam logic [1:0] CSR_MAX_LENGTH  = 2'd3;

   localparam logic [TERM_BITS-1:0] TERM_BYTES_RST = 64'd10;
   localparam logic [TLEN_BITS-1:0] TERM_LEN_RST   = 4'd1;

   typedef struct packed {
      logic [1:0] source_event;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic [TERM_BITS-1:0]   terminator_bytes;
      logic [TLEN_BITS-1:0]   terminator_length;
      logic [7:0]             escape_byte;
      logic [MAXLEN_BITS-1:0] max_length;
   } cfg_type;

endpackage

[hw/rtl/etd_term_match.sv]
// Masked compare of the shifted match window against the terminator.
// Depends on etd_pkg.
`timescale 1ns / 1ps

module etd_term_match
   import etd_pkg::*;
#(
   parameter int MAX_TERM_BYTES = MAX_TERM_BYTES_DEF
) (
   input  logic [8*MAX_TERM_BYTES-1:0] window,
   input  logic [TERM_BITS-1:0]        terminator_bytes,
   input  logic [TLEN_BITS-1:0]        terminator_length,
   output logic                        hit
);

   logic [TLEN_BITS-1:0] len_eff;

   // clamp length into 1..MAX_TERM_BYTES
   always_comb begin
      if (terminator_length == '0) begin
         len_eff = TLEN_BITS'(1);
      end else if (terminator_length > TLEN_BITS'(MAX_TERM_BYTES)) begin
         len_eff = TLEN_BITS'(MAX_TERM_BYTES);
      end else begin
         len_eff = terminator_length;
      end
   end

   always_comb begin
      hit = 1'b1;
      for (int i = 0; i < MAX_TERM_BYTES; i++) begin
         if (TLEN_BITS'(i) < len_eff &&
             window[8*i +: 8] != terminator_bytes[8*i +: 8]) begin
            hit = 1'b0;
         end
      end
   end

endmodule

[hw/rtl/etd_step.sv]
// Per-item step: escape handling, window shift, count and end detection,
// with the message state and the result register. Depends on etd_pkg, etd_term_match.
`timescale 1ns / 1ps

module etd_step
   import etd_pkg::*;
#(
   parameter int MAX_TERM_BYTES = MAX_TERM_BYTES_DEF,
   parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                in_valid,
   input  item_type            in_item,
   output logic                in_ready,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [7:0]          out_byte,
   output logic                keep_byte,
   output logic                message_done,
   output logic [2:0]          end_status,
   output logic [LEN_BITS-1:0] message_length
);

`include "escaped_terminator_detector_core_macros.svh"

   localparam int WIN_BITS = 8 * MAX_TERM_BYTES;
   localparam int CNT_BITS = COUNT_BITS + 1;
   localparam int CMP_BITS = CNT_BITS + MAXLEN_BITS;

   logic [WIN_BITS-1:0] window_ff, window_in, window_shift;
   logic                esc_pending_ff, esc_pending_in;
   logic [CNT_BITS-1:0] count_ff, count_in, count_next;

   logic                out_vld_ff, out_vld_in;
   logic [7:0]          obyte_ff;
   logic                keep_ff, done_ff;
   logic [2:0]          status_ff;
   logic [LEN_BITS-1:0] len_ff;

   logic                 advance, is_byte, is_esc, keep, matchable;
   logic                 term_hit, too_long, done;
   logic [2:0]           status;
   logic [CNT_BITS+LEN_BITS-1:0] count_wide;

   assign in_ready = !out_vld_ff || out_ready;
   assign advance  = in_valid && in_ready;

   assign is_byte   = (in_item.source_event == EV_BYTE);
   assign is_esc    = is_byte && !esc_pending_ff && (cfg.escape_byte != 8'd0) &&
                      (in_item.data_byte == cfg.escape_byte);
   assign keep      = is_byte && !is_esc;
   assign matchable = keep && !esc_pending_ff;

   assign window_shift = (window_ff << 8) | WIN_BITS'(in_item.data_byte);

   etd_term_match #(
      .MAX_TERM_BYTES(MAX_TERM_BYTES)
   ) u_match (
      .window           (window_shift),
      .terminator_bytes (cfg.terminator_bytes),
      .terminator_length(cfg.terminator_length),
      .hit              (term_hit)
   );

   // count saturates at 2**COUNT_BITS, i.e. once the top bit is set
   assign count_next = (keep && !count_ff[COUNT_BITS]) ? count_ff + CNT_BITS'(1) : count_ff;
   assign too_long   = (cfg.max_length != '0) &&
                       (CMP_BITS'(count_next) > CMP_BITS'(cfg.max_length));
   assign count_wide = {{LEN_BITS{1'b0}}, count_next};

   always_comb begin
      done   = 1'b0;
      status = ST_RUNNING;
      case (in_item.source_event)
         EV_BYTE: begin
            if (matchable && term_hit) begin
               done   = 1'b1;
               status = ST_TERM;
            end else if (too_long) begin
               done   = 1'b1;
               status = ST_TOO_LONG;
            end
         end
         EV_EOD: begin
            done   = 1'b1;
            status = ST_EOD;
         end
         EV_ERROR: begin
            done   = 1'b1;
            status = ST_ERROR;
         end
         EV_TIMEOUT: begin
            done   = 1'b1;
            status = ST_TIMEOUT;
         end
         default: begin
            done   = 1'b1;
            status = ST_EOD;
         end
      endcase
   end

   always_comb begin
      window_in      = window_ff;
      esc_pending_in = esc_pending_ff;
      count_in       = count_ff;
      if (advance) begin
         if (done) begin
            window_in      = '0;
            esc_pending_in = 1'b0;
            count_in       = '0;
         end else begin
            count_in       = count_next;
            esc_pending_in = is_esc;
            window_in      = matchable ? window_shift : '0;
         end
      end
   end

   assign out_vld_in = advance || (out_vld_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= '0;
         esc_pending_ff <= 1'b0;
         count_ff       <= '0;
         out_vld_ff     <= 1'b0;
      end else begin
         window_ff      <= window_in;
         esc_pending_ff <= esc_pending_in;
         count_ff       <= count_in;
         out_vld_ff     <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         obyte_ff  <= keep ? in_item.data_byte : 8'd0;
         keep_ff   <= keep;
         done_ff   <= done;
         status_ff <= status;
         len_ff    <= count_wide[LEN_BITS-1:0];
      end
   end

   assign out_valid      = out_vld_ff;
   assign out_byte       = obyte_ff;
   assign keep_byte      = keep_ff;
   assign message_done   = done_ff;
   assign end_status     = status_ff;
   assign message_length = len_ff;

   `ETD_ASSERT_NEXT(a_done_clears, advance && done, count_ff == '0 && window_ff == '0 && !esc_pending_ff, "message end did not clear state")
   `ETD_ASSERT_NOW(a_esc_window, esc_pending_ff, window_ff == '0, "window not cleared under pending escape")
   `ETD_ASSERT_NOW(a_drop_zero, out_vld_ff && !keep_ff, obyte_ff == 8'd0, "dropped item carries a byte")
   `ETD_ASSERT_NOW(a_status_done, out_vld_ff, (status_ff == ST_RUNNING) == !done_ff, "status disagrees with done")

endmodule

[hw/rtl/escaped_terminator_detector_core.sv]
// Escaped terminator detector, top level: config registers, input register, step stage.
// Path: an accepted req item goes through the input register, then the result register,
// which drives rsp_tvalid. Throughput: one item per cycle while rsp_tready stays high;
// the window shift, compare and count update are done in the same cycle.
// Reset: synchronous, active high; clears handshake state, message state and config registers
// (terminator 0x0A of length 1, escaping off, no length limit).
`timescale 1ns / 1ps

module escaped_terminator_detector_core
   import etd_pkg::*;
#(
   parameter int MAX_TERM_BYTES = MAX_TERM_BYTES_DEF,
   parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] source_event
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] out_byte, [24:8] message_length, rest zero
   output logic [3:0]  rsp_tuser,   // [0] keep_byte, [3:1] end_status
   output logic        rsp_tlast,   // message_done
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   // Both sides are decoupled by registers, so req_tready only drops when both stages
   // hold items and rsp_tready is low.

   cfg_type  cfg_ff, cfg_in;
   logic     in_vld_ff, in_vld_in;
   item_type in_item_ff;
   logic     step_ready, req_fire;

   logic [7:0]          out_byte;
   logic                keep_byte;
   logic [2:0]          end_status;
   logic [LEN_BITS-1:0] message_length;

   // Config writes land at once; the port never stalls.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TERM_BYTES:  cfg_in.terminator_bytes  = csr_wdata;
            CSR_TERM_LENGTH: cfg_in.terminator_length = csr_wdata[TLEN_BITS-1:0];
            CSR_ESCAPE_BYTE: cfg_in.escape_byte       = csr_wdata[7:0];
            CSR_MAX_LENGTH:  cfg_in.max_length        = csr_wdata[MAXLEN_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // Input register: take a new item whenever the slot is empty or draining.
   assign req_tready = !in_vld_ff || step_ready;
   assign req_fire   = req_tvalid && req_tready;
   assign in_vld_in  = req_fire || (in_vld_ff && !step_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff                <= 1'b0;
         cfg_ff.terminator_bytes  <= TERM_BYTES_RST;
         cfg_ff.terminator_length <= TERM_LEN_RST;
         cfg_ff.escape_byte       <= 8'd0;
         cfg_ff.max_length        <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         cfg_ff    <= cfg_in;
      end
   end

   // Hold the payload while the slot waits; load on accept.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.source_event <= req_tuser;
         in_item_ff.data_byte    <= req_tdata;
      end
   end

   // Escape handling, window match, count and result register.
   etd_step #(
      .MAX_TERM_BYTES(MAX_TERM_BYTES),
      .COUNT_BITS    (COUNT_BITS)
   ) u_step (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (in_vld_ff),
      .in_item       (in_item_ff),
      .in_ready      (step_ready),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_byte      (out_byte),
      .keep_byte     (keep_byte),
      .message_done  (rsp_tlast),
      .end_status    (end_status),
      .message_length(message_length)
   );

   assign rsp_tdata = {7'd0, message_length, out_byte};
   assign rsp_tuser = {end_status, keep_byte};

endmodule
